FILE: hw/rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants of the generational handle table: command and
// status codes, controller states and the request and result words.
// ----------------------------------------------------------------------------
package ght_pkg;

  // Default sizing of the table
  localparam int CAPACITY_DEF = 1024;
  localparam int GEN_BITS_DEF = 8;

  // Fixed field widths of the ports
  localparam int IDX_W = 10;
  localparam int GEN_W = 8;
  localparam int CFG_W = 11;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_RESOLVE = 2'd2,
    CMD_DROP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CR_WAIT,
    ST_CHK,
    ST_DEL_MV,
    ST_DEL_FIN,
    ST_DROP_RD,
    ST_DROP_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t             command;
    logic             handle_live;
    logic [IDX_W-1:0] handle_slot;
    logic [GEN_W-1:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] new_index;
    logic [GEN_W-1:0] new_generation;
    logic [IDX_W-1:0] record_index;
    logic             moved;
    logic [IDX_W-1:0] moved_slot;
    logic [GEN_W-1:0] moved_generation;
    logic [IDX_W-1:0] moved_from;
  } out_item_t;

endpackage

FILE: hw/rtl/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer of the handle table: owns the sparse and dense stores, clears
// the sparse store after reset and runs each command as a short series of
// read, modify and write steps.
// ----------------------------------------------------------------------------
module ght_ctrl import ght_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int GEN_BITS = GEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_item_t         item,
  input  logic [CFG_W-1:0] commit_limit,
  output logic             done,
  input  logic             take,
  output out_item_t        res
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int GB = GEN_BITS;
  localparam int SW = 1 + IW + GB;
  localparam int DW = IW + GB;

  state_t          state, state_next;
  logic [CW-1:0]   live_count, live_next;
  logic [CW-1:0]   high_mark, high_next;
  logic [IW-1:0]   cnt, cnt_next;
  logic [IW-1:0]   hole, hole_next;
  logic [IW-1:0]   sidx, sidx_next;
  logic [GB-1:0]   gen, gen_next;
  in_item_t        item_q;
  out_item_t       res_next;

  // Store ports
  logic            sp_we, dn_we;
  logic [IW-1:0]   sp_waddr, sp_raddr, dn_waddr, dn_raddr;
  logic [SW-1:0]   sp_wdata, sp_rdata;
  logic [DW-1:0]   dn_wdata, dn_rdata;

  // Decoded fields and derived values
  logic            sp_live;
  logic [IW-1:0]   sp_idx, dn_idx, slot, last, hidx;
  logic [GB-1:0]   sp_gen, dn_gen, sp_gen_inc, dn_gen_inc, hgen;
  logic            full, fresh, bad, stale;

  ght_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  ght_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dn_wdata),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

  // Unpack store words
  assign sp_live    = sp_rdata[SW-1];
  assign sp_idx     = sp_rdata[GB +: IW];
  assign sp_gen     = sp_rdata[GB-1:0];
  assign dn_idx     = dn_rdata[GB +: IW];
  assign dn_gen     = dn_rdata[GB-1:0];
  assign sp_gen_inc = sp_gen + GB'(1);
  assign dn_gen_inc = dn_gen + GB'(1);

  assign slot = IW'(live_count);
  assign last = IW'(live_count - CW'(1));
  assign hidx = IW'(item_q.handle_slot);
  assign hgen = GB'(item_q.handle_generation);

  // Command checks
  assign full  = (32'(live_count) >= 32'(commit_limit)) ||
                 (32'(live_count) >= 32'(CAPACITY));
  assign fresh = live_count >= high_mark;
  assign bad   = !item_q.handle_live || (live_count == '0) ||
                 (32'(item_q.handle_slot) >= 32'(CAPACITY));
  assign stale = !sp_live || (sp_gen != hgen) || (CW'(sp_idx) >= live_count);

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      live_count <= '0;
      high_mark  <= '0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      live_count <= live_next;
      high_mark  <= high_next;
      cnt        <= cnt_next;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    hole <= hole_next;
    sidx <= sidx_next;
    gen  <= gen_next;
    res  <= res_next;
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Next state, store accesses and result
  always_comb begin
    state_next = state;
    live_next  = live_count;
    high_next  = high_mark;
    cnt_next   = cnt;
    hole_next  = hole;
    sidx_next  = sidx;
    gen_next   = gen;
    res_next   = res;
    sp_we      = 1'b0;
    sp_waddr   = sidx;
    sp_wdata   = '0;
    sp_raddr   = hidx;
    dn_we      = 1'b0;
    dn_waddr   = cnt;
    dn_wdata   = '0;
    dn_raddr   = last;
    item_ready = 1'b0;
    done       = 1'b0;

    unique case (state)
      // Sweep the sparse store to zero, one entry a cycle
      ST_CLEAR: begin
        sp_we    = 1'b1;
        sp_waddr = cnt;
        if (cnt == IW'(CAPACITY - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end

      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end

      // Dispatch the command
      ST_EXEC: begin
        res_next = '0;
        unique case (item_q.command)
          CMD_CREATE: begin
            if (full) begin
              res_next.status = STAT_FULL;
              state_next      = ST_DONE;
            end else if (fresh) begin
              sp_we                 = 1'b1;
              sp_waddr              = slot;
              sp_wdata              = {1'b1, slot, GB'(0)};
              dn_we                 = 1'b1;
              dn_waddr              = slot;
              dn_wdata              = {slot, GB'(0)};
              live_next             = live_count + CW'(1);
              high_next             = live_count + CW'(1);
              res_next.new_index    = IDX_W'(slot);
              res_next.record_index = IDX_W'(slot);
              state_next            = ST_DONE;
            end else begin
              dn_raddr   = slot;
              state_next = ST_CR_WAIT;
            end
          end
          CMD_DELETE, CMD_RESOLVE: begin
            if (bad) begin
              res_next.status = STAT_NOT_FOUND;
              state_next      = ST_DONE;
            end else begin
              state_next = ST_CHK;
            end
          end
          CMD_DROP: begin
            if (live_count == '0) begin
              state_next = ST_DONE;
            end else begin
              cnt_next   = '0;
              dn_raddr   = '0;
              state_next = ST_DROP_WR;
            end
          end
        endcase
      end

      // Reuse the freed slot parked just past the live items
      ST_CR_WAIT: begin
        sp_we                   = 1'b1;
        sp_waddr                = dn_idx;
        sp_wdata                = {1'b1, slot, dn_gen};
        dn_we                   = 1'b1;
        dn_waddr                = slot;
        dn_wdata                = {dn_idx, dn_gen};
        live_next               = live_count + CW'(1);
        res_next.new_index      = IDX_W'(dn_idx);
        res_next.new_generation = GEN_W'(dn_gen);
        res_next.record_index   = IDX_W'(slot);
        state_next              = ST_DONE;
      end

      // Check the sparse entry; resolve ends here, delete frees the slot
      ST_CHK: begin
        if (stale) begin
          res_next.status = STAT_NOT_FOUND;
          state_next      = ST_DONE;
        end else if (item_q.command == CMD_RESOLVE) begin
          res_next.record_index = IDX_W'(sp_idx);
          state_next            = ST_DONE;
        end else begin
          hole_next             = sp_idx;
          gen_next              = sp_gen_inc;
          sidx_next             = hidx;
          sp_we                 = 1'b1;
          sp_waddr              = hidx;
          sp_wdata              = {1'b0, IW'(0), sp_gen_inc};
          res_next.record_index = IDX_W'(sp_idx);
          if (sp_idx == last) begin
            dn_we      = 1'b1;
            dn_waddr   = last;
            dn_wdata   = {hidx, sp_gen_inc};
            live_next  = live_count - CW'(1);
            state_next = ST_DONE;
          end else begin
            dn_raddr   = last;
            state_next = ST_DEL_MV;
          end
        end
      end

      // Move the last live item into the hole
      ST_DEL_MV: begin
        sp_we                     = 1'b1;
        sp_waddr                  = dn_idx;
        sp_wdata                  = {1'b1, hole, dn_gen};
        dn_we                     = 1'b1;
        dn_waddr                  = hole;
        dn_wdata                  = {dn_idx, dn_gen};
        res_next.moved            = 1'b1;
        res_next.moved_slot       = IDX_W'(dn_idx);
        res_next.moved_generation = GEN_W'(dn_gen);
        res_next.moved_from       = IDX_W'(last);
        state_next                = ST_DEL_FIN;
      end

      // Park the freed slot just past the live items
      ST_DEL_FIN: begin
        dn_we      = 1'b1;
        dn_waddr   = last;
        dn_wdata   = {sidx, gen};
        live_next  = live_count - CW'(1);
        state_next = ST_DONE;
      end

      ST_DROP_RD: begin
        dn_raddr   = cnt;
        state_next = ST_DROP_WR;
      end

      // Free one live entry and bump its generation
      ST_DROP_WR: begin
        sp_we    = 1'b1;
        sp_waddr = dn_idx;
        sp_wdata = {1'b0, IW'(0), dn_gen_inc};
        dn_we    = 1'b1;
        dn_waddr = cnt;
        dn_wdata = {dn_idx, dn_gen_inc};
        if (CW'(cnt) + CW'(1) == live_count) begin
          live_next  = '0;
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next   = cnt + IW'(1);
          state_next = ST_DROP_RD;
        end
      end

      // Hold the result until the output register takes it
      ST_DONE: begin
        done = 1'b1;
        if (take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/generational_handle_table_unit.sv
// Flow: one item at a time; the next item is taken in the idle state entered when the
// result enters the output register.
// Reset: counts clear at once, then the sparse store is swept to zero over all CAPACITY
// entries with no item taken; commit_limit resets to 1024.
// ----------------------------------------------------------------------------
// generational_handle_table_unit
// Generational handle table with sparse and dense stores: create, delete
// with swap-remove, resolve and drop-all, behind a registered result port.
// ----------------------------------------------------------------------------
module generational_handle_table_unit import ght_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int GEN_BITS = GEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_item_t         item,
  output logic             result_valid,
  input  logic             result_ready,
  output out_item_t        result,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] commit_limit;
  logic             done;
  logic             take;
  out_item_t        res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      commit_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      commit_limit <= cfg_wdata;
    end
  end

  ght_ctrl #(.CAPACITY(CAPACITY), .GEN_BITS(GEN_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .commit_limit (commit_limit),
    .done         (done),
    .take         (take),
    .res          (res)
  );

  // Load the output register when it is empty or being drained
  assign take = done && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

endmodule
